// ===== sv/triangle_face_normal_macros.svh =====
// Assertion macros for the triangle face normal checker.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// same-cycle implication, idle during reset
`define TFN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle_face_normal check failed");

// next-cycle implication, idle during reset
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle_face_normal check failed");

// next-cycle implication that also holds through reset
`define TFN_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("triangle_face_normal check failed");

`endif

// ===== sv/tfn_pkg.sv =====
// Shared constants and types for the triangle face normal block.
package tfn_pkg;

  localparam int FIELD_BITS           = 16;
  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int IN_DATA_BITS         = 9 * FIELD_BITS;
  localparam int OUT_DATA_BITS        = 3 * FIELD_BITS;

  localparam int PRESCALE_BITS = 26;
  localparam int GUARD_BITS    = 4;
  localparam int SQ_BITS       = 2 * PRESCALE_BITS + 2;
  localparam int RAD_BITS      = SQ_BITS + 2 * GUARD_BITS;
  localparam int ROOT_BITS     = RAD_BITS / 2;

  typedef struct packed {
    logic                          degen;
    logic [2:0]                    neg;
    logic [2:0][PRESCALE_BITS-1:0] mag;
  } side_t;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } dside_t;

endpackage

// ===== sv/tfn_sqrt_cell.sv =====
// One result bit of the pipelined integer square root.
module tfn_sqrt_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [tfn_pkg::RAD_BITS-1:0]   in_rad,
  input  logic [tfn_pkg::ROOT_BITS:0]    in_rem,
  input  logic [tfn_pkg::ROOT_BITS-1:0]  in_root,
  input  tfn_pkg::side_t                 in_side,
  output logic                           out_valid,
  output logic [tfn_pkg::RAD_BITS-1:0]   out_rad,
  output logic [tfn_pkg::ROOT_BITS:0]    out_rem,
  output logic [tfn_pkg::ROOT_BITS-1:0]  out_root,
  output tfn_pkg::side_t                 out_side
);
  import tfn_pkg::*;

  logic [ROOT_BITS+2:0] cur;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] diff;
  logic                 ge;

  always_comb begin
    cur   = {in_rem, in_rad[RAD_BITS-1 -: 2]};
    trial = {1'b0, in_root, 2'b01};
    ge    = cur >= trial;
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= in_rad << 2;
      out_rem  <= ge ? diff[ROOT_BITS:0] : cur[ROOT_BITS:0];
      out_root <= {in_root[ROOT_BITS-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule

// ===== sv/tfn_div_cell.sv =====
// One quotient bit of the three-lane restoring divider.
module tfn_div_cell #(
  parameter int QB = tfn_pkg::NORMAL_FRAC_BITS_DEF + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [tfn_pkg::ROOT_BITS-1:0]       in_r,
  input  logic [2:0][tfn_pkg::ROOT_BITS-1:0]  in_rem,
  input  logic [2:0][QB-1:0]                  in_low,
  input  tfn_pkg::dside_t                     in_side,
  output logic                                out_valid,
  output logic [tfn_pkg::ROOT_BITS-1:0]       out_r,
  output logic [2:0][tfn_pkg::ROOT_BITS-1:0]  out_rem,
  output logic [2:0][QB-1:0]                  out_low,
  output tfn_pkg::dside_t                     out_side
);
  import tfn_pkg::*;

  logic [2:0][ROOT_BITS:0]   cur;
  logic [2:0][ROOT_BITS:0]   diff;
  logic [2:0]                ge;
  logic [2:0][ROOT_BITS-1:0] rem_next;
  logic [2:0][QB-1:0]        low_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i]      = {in_rem[i], in_low[i][QB-1]};
      ge[i]       = cur[i] >= {1'b0, in_r};
      diff[i]     = cur[i] - {1'b0, in_r};
      rem_next[i] = ge[i] ? diff[i][ROOT_BITS-1:0] : cur[i][ROOT_BITS-1:0];
      low_next[i] = {in_low[i][QB-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r    <= in_r;
      out_rem  <= rem_next;
      out_low  <= low_next;
      out_side <= in_side;
    end
  end

endmodule

// ===== sv/triangle_face_normal.sv =====
// Top level: unit face normal of one triangle per item.
//
// Input channel s_axis: one triangle per item, nine 16-bit corner coordinates
// packed in tdata (a_x lowest, then a_y, a_z, b_x ... c_z). Output channel
// m_axis: norm_x, norm_y, norm_z in tdata (Q1.14 by default), and tuser set
// when the corners are collinear or coincide, with the normal then zero.
// One triangle is taken per cycle while s_axis_tready is high. The pipeline
// holds eight front stages (edges, products, cross product, magnitude, shift
// count, prescale, squares, sum), 31 square-root cells, one divider setup
// stage, NORMAL_FRAC_BITS + 1 divider cells and the output register.
// The pipeline moves as a whole; a skid register behind the output register
// catches the item leaving the pipeline when the receiver stalls, and
// s_axis_tready falls only while that skid register is full.
// Synchronous reset empties the pipeline, output and skid registers; no
// other state is kept between items.
module triangle_face_normal #(
  parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [tfn_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // norm_x, norm_y, norm_z
  output logic [tfn_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // degenerate
  output logic                               m_axis_tuser
);
  import tfn_pkg::*;

  localparam int EW   = COORD_BITS + 1;
  localparam int PW   = 2 * EW;
  localparam int NSW  = PW + 1;
  localparam int MAGW = PW;
  localparam int XW   = (MAGW > PRESCALE_BITS) ? MAGW : PRESCALE_BITS + 1;
  localparam int SHN  = XW - PRESCALE_BITS;
  localparam int SHW  = $clog2(SHN + 1);
  localparam int QB   = NORMAL_FRAC_BITS + 1;
  localparam int NW   = PRESCALE_BITS + NORMAL_FRAC_BITS + GUARD_BITS + 1;
  localparam int OXW  = (QB + 1 > FIELD_BITS) ? QB + 1 : FIELD_BITS;
  localparam logic [QB-1:0] Q_ONE = QB'(1) << NORMAL_FRAC_BITS;

  logic skid_valid;
  logic en;
  assign en = ~skid_valid;
  assign s_axis_tready = en;

  // corners and edges
  logic [FIELD_BITS+COORD_BITS-1:0] wide [9];
  logic signed [COORD_BITS-1:0]     crd [9];
  logic signed [EW-1:0]             e1_d [3];
  logic signed [EW-1:0]             e2_d [3];
  logic signed [EW-1:0]             e1 [3];
  logic signed [EW-1:0]             e2 [3];
  logic                             v1;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      wide[k] = {{COORD_BITS{1'b0}}, s_axis_tdata[k*FIELD_BITS +: FIELD_BITS]};
      crd[k]  = signed'(wide[k][COORD_BITS-1:0]);
    end
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = EW'(crd[3+i]) - EW'(crd[i]);
      e2_d[i] = EW'(crd[6+i]) - EW'(crd[i]);
    end
  end

  // products, cross product, magnitudes
  logic signed [PW-1:0]  p [6];
  logic signed [NSW-1:0] n [3];
  logic [MAGW-1:0]       mag4 [3];
  dside_t                ds4;
  logic                  v2, v3, v4;

  // shift count, prescale, squares, sum
  logic [XW-1:0]              orv;
  logic [SHW-1:0]             sh_d;
  logic [XW-1:0]              mag5 [3];
  logic [SHW-1:0]             sh5;
  dside_t                     ds5;
  side_t                      s6;
  side_t                      s7;
  logic [2*PRESCALE_BITS-1:0] sq7 [3];
  logic                       v5, v6, v7;

  always_comb begin
    orv  = XW'(mag4[0] | mag4[1] | mag4[2]);
    sh_d = '0;
    for (int i = 0; i < SHN; i++) begin
      if (orv[PRESCALE_BITS+i]) begin
        sh_d = SHW'(i + 1);
      end
    end
  end

  // square-root chain
  logic                 sq_v    [ROOT_BITS+1];
  logic [RAD_BITS-1:0]  sq_rad  [ROOT_BITS+1];
  logic [ROOT_BITS:0]   sq_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_root [ROOT_BITS+1];
  side_t                sq_side [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      sq_v[0] <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= e1_d[i];
        e2[i] <= e2_d[i];
      end
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        n[i] <= NSW'(p[2*i]) - NSW'(p[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
        ds4.neg[i] <= n[i][NSW-1];
        mag4[i]    <= n[i][NSW-1] ? MAGW'(-n[i]) : MAGW'(n[i]);
      end
      ds4.degen <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
      for (int i = 0; i < 3; i++) begin
        mag5[i] <= XW'(mag4[i]);
      end
      sh5 <= sh_d;
      ds5 <= ds4;
      for (int i = 0; i < 3; i++) begin
        s6.mag[i] <= PRESCALE_BITS'(mag5[i] >> sh5);
      end
      s6.neg   <= ds5.neg;
      s6.degen <= ds5.degen;
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= s6.mag[i] * s6.mag[i];
      end
      s7 <= s6;
      sq_rad[0]  <= {SQ_BITS'(sq7[0]) + SQ_BITS'(sq7[1]) + SQ_BITS'(sq7[2]),
                     {(2*GUARD_BITS){1'b0}}};
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_side[0] <= s7;
    end
  end

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_v[g]),
      .in_rad    (sq_rad[g]),
      .in_rem    (sq_rem[g]),
      .in_root   (sq_root[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_v[g+1]),
      .out_rad   (sq_rad[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_root  (sq_root[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // divider setup and chain
  logic                           dv    [QB+1];
  logic [ROOT_BITS-1:0]           dr    [QB+1];
  logic [2:0][ROOT_BITS-1:0]      drem  [QB+1];
  logic [2:0][QB-1:0]             dlow  [QB+1];
  dside_t                         dside [QB+1];
  logic [NW-1:0]                  num   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(sq_side[ROOT_BITS].mag[i]) << (NORMAL_FRAC_BITS + GUARD_BITS))
             + NW'(sq_root[ROOT_BITS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sq_v[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0] <= sq_root[ROOT_BITS];
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= ROOT_BITS'(num[i][NW-1:QB]);
        dlow[0][i] <= num[i][QB-1:0];
      end
      dside[0].neg   <= sq_side[ROOT_BITS].neg;
      dside[0].degen <= sq_side[ROOT_BITS].degen;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    tfn_div_cell #(.QB(QB)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv[g]),
      .in_r      (dr[g]),
      .in_rem    (drem[g]),
      .in_low    (dlow[g]),
      .in_side   (dside[g]),
      .out_valid (dv[g+1]),
      .out_r     (dr[g+1]),
      .out_rem   (drem[g+1]),
      .out_low   (dlow[g+1]),
      .out_side  (dside[g+1])
    );
  end

  // sign, limit and output staging
  logic [QB-1:0]            qc   [3];
  logic [OXW-1:0]           qe   [3];
  logic [OXW-1:0]           qs   [3];
  logic [OUT_DATA_BITS-1:0] pipe_data;
  logic                     pipe_user;
  logic                     pv;
  logic                     out_valid;
  logic [OUT_DATA_BITS-1:0] out_data;
  logic                     out_user;
  logic [OUT_DATA_BITS-1:0] skid_data;
  logic                     skid_user;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dlow[QB][i] > Q_ONE) ? Q_ONE : dlow[QB][i];
      qe[i] = OXW'(qc[i]);
      qs[i] = dside[QB].neg[i] ? -qe[i] : qe[i];
      pipe_data[i*FIELD_BITS +: FIELD_BITS] =
        dside[QB].degen ? '0 : qs[i][FIELD_BITS-1:0];
    end
    pipe_user = dside[QB].degen;
    pv        = dv[QB] && en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= pv;
    end else if (pv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end
    end else if (!out_valid || m_axis_tready) begin
      out_data <= pipe_data;
      out_user <= pipe_user;
    end else begin
      skid_data <= pipe_data;
      skid_user <= pipe_user;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

endmodule

// ===== sv/tfn_checker.sv =====
// Port-level checks for triangle_face_normal, bound to the top level.
`include "triangle_face_normal_macros.svh"

module tfn_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [tfn_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input logic                               m_axis_tuser
);

  `TFN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  `TFN_ASSERT_NOW(a_degen_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

  `TFN_ASSERT_NOW(a_normal_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != '0)

  `TFN_ASSERT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/triangle_face_normal_tb.sv =====
// Testbench for triangle_face_normal: directed and random triangles checked against a predictor.
module triangle_face_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfn_pkg::*;

  localparam int LATENCY = 56;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic        degen;
  } normal_t;

  typedef struct {
    logic [15:0] crd [9];
    bit          known;
    normal_t     res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;

  triangle_face_normal u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  normal_t expected_normals [$];
  int      errors = 0;
  int      n_items = 0;
  int      n_results = 0;
  int      n_degen = 0;
  int      send_idle = 34;
  int      recv_idle = 72;
  int      hold_cycles = 0;
  longint  cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(logic [15:0] crd [9]);
    longint p [9];
    longint e1 [3], e2 [3], n [3];
    longint unsigned mag [3], mx, s, r, q;
    int len, sh;
    logic [15:0] comp [3];
    normal_t o;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(crd[i]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[6+i] - p[i];
    end
    n[0] = e1[1]*e2[2] - e1[2]*e2[1];
    n[1] = e1[2]*e2[0] - e1[0]*e2[2];
    n[2] = e1[0]*e2[1] - e1[1]*e2[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) return '{16'd0, 16'd0, 16'd0, 1'b1};
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? longint'(-n[i]) : longint'(n[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    len = 0;
    while (mx != 0) begin
      len++;
      mx >>= 1;
    end
    sh = len > PRESCALE_BITS ? len - PRESCALE_BITS : 0;
    for (int i = 0; i < 3; i++) mag[i] >>= sh;
    s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
    r = root_floor(s << (2*GUARD_BITS));
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (r != 0) q = ((mag[i] << (NORMAL_FRAC_BITS_DEF + GUARD_BITS)) + (r >> 1)) / r;
      if (q > (64'd1 << NORMAL_FRAC_BITS_DEF)) q = 64'd1 << NORMAL_FRAC_BITS_DEF;
      if (n[i] < 0) q = -q;
      comp[i] = q[15:0];
    end
    o.nx = comp[0];
    o.ny = comp[1];
    o.nz = comp[2];
    o.degen = 1'b0;
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    normal_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser};
      n_results++;
      if (expected_normals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_normals.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h y=%h z=%h d=%b got x=%h y=%h z=%h d=%b",
                     want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
        end
      end
    end
  end

  task automatic send_triangle(logic [15:0] crd [9]);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {crd[8], crd[7], crd[6], crd[5], crd[4], crd[3], crd[2], crd[1], crd[0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_normals = {expected_normals, face_normal(crd)};
    if (face_normal(crd).degen) n_degen++;
    n_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_normals.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3)) : 16'h8000 + 16'($urandom_range(3));
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  initial begin
    row_t dir [$];
    row_t rw;
    logic [15:0] crd [9];
    int mode;
    // unit right triangles on the axis planes: normals +z, -z, +x and +y
    rw.crd = '{0,0,0, 1,0,0, 0,1,0}; rw.known = 1; rw.res = '{0, 0, 16'd16384, 0};
    dir = {dir, rw};
    rw.crd = '{0,0,0, 0,1,0, 1,0,0}; rw.res = '{0, 0, 16'hc000, 0};
    dir = {dir, rw};
    rw.crd = '{0,0,0, 0,1,0, 0,0,1}; rw.res = '{16'd16384, 0, 0, 0};
    dir = {dir, rw};
    rw.crd = '{0,0,0, 0,0,1, 1,0,0}; rw.res = '{0, 16'd16384, 0, 0};
    dir = {dir, rw};
    // coincident and collinear corners
    rw.crd = '{5,5,5, 5,5,5, 5,5,5}; rw.res = '{0, 0, 0, 1};
    dir = {dir, rw};
    rw.crd = '{16'h8000,16'h8000,16'h8000, 0,0,0, 16'h7fff,16'h7fff,16'h7fff};
    rw.res = '{0, 0, 0, 1};
    dir = {dir, rw};
    rw.crd = '{1,2,3, 2,4,6, 3,6,9}; rw.res = '{0, 0, 0, 1};
    dir = {dir, rw};
    rw.known = 0;
    rw.crd = '{16'h8000,16'h8000,16'h8000, 16'h7fff,16'h8000,16'h8000, 16'h8000,16'h7fff,16'h8000};
    dir = {dir, rw};
    rw.crd = '{16'h8000,16'h8000,16'h7fff, 16'h7fff,16'h8000,16'h8000, 16'h8000,16'h7fff,16'h8000};
    dir = {dir, rw};
    rw.crd = '{16'h7fff,16'h8000,16'h7fff, 16'h8000,16'h7fff,16'h8000, 16'h7fff,16'h7fff,16'h8000};
    dir = {dir, rw};
    rw.crd = '{0,0,0, 1,1,1, 1,1,2};
    dir = {dir, rw};
    rw.crd = '{16'hffff,16'hffff,16'hffff, 16'hfffe,16'hffff,16'hffff, 16'hffff,16'hfffe,16'h0};
    dir = {dir, rw};
    rw.crd = '{0,0,0, 16'h7fff,0,0, 0,1,0};
    dir = {dir, rw};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir[k]) begin
      if (dir[k].known && face_normal(dir[k].crd) != dir[k].res) begin
        errors++;
        $display("directed row %0d: predictor disagrees with table", k);
      end
      send_triangle(dir[k].crd);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 34 : (phase == 1 ? 72 : 0);
      recv_idle = phase == 0 ? 72 : (phase == 1 ? 34 : 0);
      for (int k = 0; k < 400; k++) begin
        if (phase == 2 && k == 50) hold_cycles = 300;
        mode = $urandom_range(3);
        for (int i = 0; i < 9; i++) crd[i] = rand_coord(mode);
        // occasional collinear triangle
        if ($urandom_range(19) == 0)
          for (int i = 0; i < 3; i++) crd[6+i] = crd[3+i] + (crd[3+i] - crd[i]);
        send_triangle(crd);
        if (k == 200) drain();
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("Covered %0d triangles (%0d degenerate) and %0d results under three stall mixes",
             n_items, n_degen, n_results);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
